@@ design/nalf_pkg.sv @@
// ----------------------------------------------------------------------------
// nalf_pkg
// shared types, constants and type-rule function for the nal unit filter
// ----------------------------------------------------------------------------
package nalf_pkg;

  localparam int WIN_DEPTH = 5;

  typedef logic [7:0] byte_t;
  typedef logic [WIN_DEPTH-1:0][7:0] win_t;
  typedef logic [2:0] fill_t;

  // codec_select codes
  localparam logic CODEC_H264 = 1'b0;
  localparam logic CODEC_H265 = 1'b1;

  // unit types that are dropped
  localparam logic [4:0] H264_SEI = 5'd6;
  localparam logic [4:0] H264_AUD = 5'd9;
  localparam logic [5:0] H265_AUD = 6'd35;
  localparam logic [5:0] H265_SEI = 6'd39;

  // per-unit tracking carried across released bytes
  typedef struct packed {
    logic [2:0] unit_offset;  // saturates at 7
    logic [1:0] zero_run;     // saturates at 2
    logic       keep_unit;
  } unit_state_t;

  localparam unit_state_t UNIT_STATE_RESET = '{unit_offset: 3'd0, zero_run: 2'd0,
                                               keep_unit: 1'b1};

  typedef struct packed {
    logic        kept;    // oldest byte goes out
    unit_state_t st;      // tracking after the release
  } release_t;

  function automatic logic type_dropped(input logic codec, input byte_t t);
    logic drop;
    if (codec == CODEC_H264) begin
      drop = (t[4:0] == H264_SEI) || (t[4:0] == H264_AUD);
    end else begin
      drop = (t[6:1] == H265_AUD) || (t[6:1] == H265_SEI);
    end
    return drop;
  endfunction

endpackage

@@ design/nalf_release.sv @@
// ----------------------------------------------------------------------------
// nalf_release
// start-code detection and keep decision for the oldest byte of the window
// ----------------------------------------------------------------------------
module nalf_release (
  input  nalf_pkg::win_t        win,
  input  nalf_pkg::fill_t       fill,
  input  nalf_pkg::unit_state_t st,
  input  logic                  codec,
  output nalf_pkg::release_t    rel
);

  logic            sc4;
  logic            sc3;
  logic            starts;
  logic            type_avail;
  nalf_pkg::byte_t type_byte;
  logic            keep_new;

  // start code with a leading zero byte, and a plain start code
  assign sc4 = (st.unit_offset >= 3'd2) && (fill >= 3'd4) && (win[0] == 8'h00) &&
               (win[1] == 8'h00) && (win[2] == 8'h00) && (win[3] == 8'h01);
  assign sc3 = (st.unit_offset >= 3'd3) && (st.zero_run == 2'd0) && (fill >= 3'd3) &&
               (win[0] == 8'h00) && (win[1] == 8'h00) && (win[2] == 8'h01);
  assign starts = (st.unit_offset == 3'd0) || sc4 || sc3;

  // type byte at offset 4 after a zero at offset 2, else at offset 3
  assign type_byte  = (win[2] == 8'h00) ? win[4] : win[3];
  assign type_avail = (win[2] == 8'h00) ? (fill >= 3'd5) : (fill >= 3'd4);
  assign keep_new   = type_avail ? !nalf_pkg::type_dropped(codec, type_byte) : 1'b1;

  always_comb begin
    rel.kept         = starts ? keep_new : st.keep_unit;
    rel.st.keep_unit = rel.kept;
    if (win[0] == 8'h00) begin
      rel.st.zero_run = (st.zero_run == 2'd2) ? 2'd2 : st.zero_run + 2'd1;
    end else begin
      rel.st.zero_run = 2'd0;
    end
    if (starts) begin
      rel.st.unit_offset = 3'd1;
    end else begin
      rel.st.unit_offset = (st.unit_offset == 3'd7) ? 3'd7 : st.unit_offset + 3'd1;
    end
  end

endmodule

@@ design/nal_unit_type_filter_top.sv @@
// ----------------------------------------------------------------------------
// nal_unit_type_filter_top
// annex b byte stream filter that drops sei and access unit delimiter units
// ----------------------------------------------------------------------------
//  channel   direction  signals                        contents
//  s_*       in         s_tvalid s_tready s_tdata      in_byte; s_tlast = in_last
//                       s_tlast
//  m_*       out        m_tvalid m_tready m_tdata      out_byte; m_tuser = byte_valid;
//                       m_tlast m_tuser                m_tlast = packet_end
//  cfg_*     in         cfg_valid cfg_ready cfg_data   codec_select (0 h.264, 1 h.265)
//
//  one byte request per clock inside a packet unless stalled; a kept byte leaves
//  four bytes later. the last byte of a packet starts a drain of the delay window
//  releasing each held byte (up to 5), then the end result; s_tready low meanwhile
//  synchronous active-high rst clears all control state and selects h.264 rules
//  m_tready low stalls the input only when a new byte would have to release one
// ----------------------------------------------------------------------------
module nal_unit_type_filter_top (
  input  logic       clk,
  input  logic       rst,
  // byte input
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tlast,
  // filtered output
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tlast,
  output logic       m_tuser,   // [0] byte_valid
  // configuration
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data
);

  // packets shorter than this give only the end result
  localparam logic [2:0] PKT_MIN = 3'd4;

  // window and tracking state
  nalf_pkg::win_t        win, win_next;
  nalf_pkg::fill_t       fill, fill_next;
  nalf_pkg::unit_state_t st, st_next;
  logic [2:0]            pcount, pcount_next;
  logic                  drain, drain_next;
  logic                  hold_valid, hold_valid_next;
  nalf_pkg::byte_t       hold_byte, hold_byte_next;
  logic                  codec;

  // release path
  nalf_pkg::win_t        push_win;
  nalf_pkg::win_t        rel_win;
  nalf_pkg::win_t        shift_win;
  nalf_pkg::fill_t       rel_fill;
  nalf_pkg::release_t    rel;

  // output load
  logic                  in_fire;
  logic                  out_free;
  logic                  out_load;
  nalf_pkg::byte_t       out_byte;
  logic                  out_user;
  logic                  out_end;

  assign out_free  = !m_tvalid || m_tready;
  // a byte only forces a release when the window is one short of full
  assign s_tready  = !drain && ((fill != nalf_pkg::fill_t'(nalf_pkg::WIN_DEPTH - 1)) ||
                                out_free);
  assign in_fire   = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  // new byte goes into the first free slot
  always_comb begin
    for (int k = 0; k < nalf_pkg::WIN_DEPTH; k++) begin
      push_win[k] = (fill == nalf_pkg::fill_t'(k)) ? s_tdata : win[k];
    end
  end

  // one release unit, shared: input path and drain never run in the same cycle
  assign rel_win   = drain ? win : push_win;
  assign rel_fill  = drain ? fill : nalf_pkg::fill_t'(nalf_pkg::WIN_DEPTH);
  assign shift_win = {8'h00, rel_win[nalf_pkg::WIN_DEPTH-1:1]};

  nalf_release u_release (
    .win   (rel_win),
    .fill  (rel_fill),
    .st    (st),
    .codec (codec),
    .rel   (rel)
  );

  always_comb begin
    win_next        = win;
    fill_next       = fill;
    st_next         = st;
    pcount_next     = pcount;
    drain_next      = drain;
    hold_valid_next = hold_valid;
    hold_byte_next  = hold_byte;
    out_load        = 1'b0;
    out_byte        = 8'h00;
    out_user        = 1'b0;
    out_end         = 1'b0;
    if (in_fire) begin
      pcount_next = (pcount == PKT_MIN) ? pcount : pcount + 3'd1;
      if (!s_tlast) begin
        if (fill == nalf_pkg::fill_t'(nalf_pkg::WIN_DEPTH - 1)) begin
          // window full: oldest byte is decided and leaves
          win_next = shift_win;
          st_next  = rel.st;
          if (rel.kept) begin
            out_load = 1'b1;
            out_byte = push_win[0];
            out_user = 1'b1;
          end
        end else begin
          win_next  = push_win;
          fill_next = fill + 3'd1;
        end
      end else begin
        drain_next = 1'b1;
        if (pcount_next < PKT_MIN) begin
          // short packet: nothing is released
          fill_next = 3'd0;
        end else begin
          win_next  = push_win;
          fill_next = fill + 3'd1;
        end
      end
    end else if (drain && out_free) begin
      if (fill != 3'd0) begin
        // kept bytes wait in the hold register so the last one can carry the end flag
        win_next  = shift_win;
        fill_next = fill - 3'd1;
        st_next   = rel.st;
        if (rel.kept) begin
          hold_byte_next  = win[0];
          hold_valid_next = 1'b1;
          if (hold_valid) begin
            out_load = 1'b1;
            out_byte = hold_byte;
            out_user = 1'b1;
          end
        end
      end else begin
        // end result: last kept byte, or an empty marker
        out_load        = 1'b1;
        out_end         = 1'b1;
        out_user        = hold_valid;
        out_byte        = hold_valid ? hold_byte : 8'h00;
        hold_valid_next = 1'b0;
        drain_next      = 1'b0;
        st_next         = nalf_pkg::UNIT_STATE_RESET;
        pcount_next     = 3'd0;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      fill       <= 3'd0;
      st         <= nalf_pkg::UNIT_STATE_RESET;
      pcount     <= 3'd0;
      drain      <= 1'b0;
      hold_valid <= 1'b0;
      codec      <= nalf_pkg::CODEC_H264;
      m_tvalid   <= 1'b0;
    end else begin
      fill       <= fill_next;
      st         <= st_next;
      pcount     <= pcount_next;
      drain      <= drain_next;
      hold_valid <= hold_valid_next;
      if (cfg_valid && cfg_ready) begin
        codec <= cfg_data;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    win       <= win_next;
    hold_byte <= hold_byte_next;
    if (out_load) begin
      m_tdata <= out_byte;
      m_tuser <= out_user;
      m_tlast <= out_end;
    end
  end

endmodule

@@ design/nalf_checker.sv @@
// ----------------------------------------------------------------------------
// nalf_checker
// port-level checks for the nal unit filter, bound to the top level
// ----------------------------------------------------------------------------
module nalf_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       s_tlast,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast,
  input logic       m_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast) &&
                              $stable(m_tuser))
    else $error("output result changed under stall");

  // a result without a byte is only the packet end marker
  a_empty_is_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tlast && (m_tdata == 8'h00))
    else $error("empty result that is not a clean end marker");

  // the last byte of a packet starts a drain that blocks new requests
  a_drain_blocks: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("input accepted right after packet end");

endmodule

bind nal_unit_type_filter_top nalf_checker u_nalf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

@@ bench/tb_nal_unit_type_filter_top.sv @@
// ----------------------------------------------------------------------------
// tb_nal_unit_type_filter_top
// checks the annex b unit filter against a cycle-free byte predictor
// ----------------------------------------------------------------------------
// bytes are pushed through the s_* stream and every m_* result is compared
// with a queue of predicted results. the predictor mirrors the five-byte
// lookahead window: start code detection, type byte lookup and the drain at
// packet end. directed packets cover short packets, dropped and kept units
// for both codecs and a unit cut off before its type byte; random packets
// are mostly well-formed unit chains with some noise and truncation.
// ----------------------------------------------------------------------------
module tb_nal_unit_type_filter_top;

  localparam int HOLD_DEPTH  = 5;       // bytes held before a decision
  localparam int MAX_PER_REQ = 6;       // bound on the results one request can cause
  localparam int SETTLE      = 10;      // quiet cycles once all results have left
  localparam int CYCLE_LIMIT = 200000;  // far above the slowest correct run
  localparam int RAND_ITEMS  = 450;

  // one filtered result as it leaves on m_*
  typedef struct packed {
    nalf_pkg::byte_t out_byte;
    logic            byte_valid;
    logic            packet_end;
  } filt_res_t;

  logic  clk;
  logic  rst;
  logic  s_tvalid;
  logic  s_tready;
  logic  [7:0] s_tdata;  // [7:0] in_byte
  logic  s_tlast;        // in_last
  logic  m_tvalid;
  logic  m_tready;
  logic  [7:0] m_tdata;  // [7:0] out_byte
  logic  m_tlast;        // packet_end
  logic  m_tuser;        // [0] byte_valid
  logic  cfg_valid;
  logic  cfg_ready;
  logic  cfg_data;

  nal_unit_type_filter_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  // 2 time unit clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // ------------------------------------------------------------------------
  // predictor state: the held bytes and the tracking of the current unit
  // ------------------------------------------------------------------------
  nalf_pkg::byte_t hold_win [HOLD_DEPTH];
  int          hold_cnt;
  logic [1:0]  zeros_seen;   // zero run ending at the last released byte, max 2
  logic [2:0]  unit_pos;     // offset of the next released byte, max 7
  logic        unit_kept;
  logic [2:0]  pkt_len;      // bytes seen in this packet, max 7
  logic        codec_h265;   // copy of codec_select

  filt_res_t   step_out[$];     // results of the request being predicted
  filt_res_t   filtered_q[$];   // results still to come from the block
  filt_res_t   seen_res;
  filt_res_t   want_res;

  int          errors;
  int          cycles;
  int          sent;
  bit          steady;          // receiver never stalls and send_byte adds no idles while set

  function automatic void clear_packet();
    foreach (hold_win[k]) hold_win[k] = 8'h00;
    hold_cnt   = 0;
    zeros_seen = 2'd0;
    unit_pos   = 3'd0;
    unit_kept  = 1'b1;
    pkt_len    = 3'd0;
  endfunction

  // type rule of the selected codec: sei and access unit delimiters go
  function automatic logic unit_dropped(input nalf_pkg::byte_t t);
    logic [4:0] t264;
    logic [5:0] t265;
    t264 = t[4:0];
    t265 = t[6:1];
    if (codec_h265 == nalf_pkg::CODEC_H264) begin
      return (t264 == nalf_pkg::H264_SEI) || (t264 == nalf_pkg::H264_AUD);
    end
    return (t265 == nalf_pkg::H265_AUD) || (t265 == nalf_pkg::H265_SEI);
  endfunction

  // releases the oldest held byte, deciding on a new unit from the lookahead
  function automatic void emit_head();
    logic starts;
    int   type_at;
    if (hold_cnt == 0) return;
    starts = 1'b0;
    if (unit_pos == 3'd0) begin
      starts = 1'b1;
    end else if (unit_pos >= 3'd2 && hold_cnt >= 4 && hold_win[0] == 8'h00 &&
                 hold_win[1] == 8'h00 && hold_win[2] == 8'h00 && hold_win[3] == 8'h01) begin
      // zero byte in front of a start code opens the new unit
      starts = 1'b1;
    end else if (unit_pos >= 3'd3 && zeros_seen == 2'd0 && hold_cnt >= 3 &&
                 hold_win[0] == 8'h00 && hold_win[1] == 8'h00 && hold_win[2] == 8'h01) begin
      starts = 1'b1;
    end
    if (starts) begin
      unit_pos  = 3'd0;
      unit_kept = 1'b1;
      if (hold_cnt >= 3) begin
        type_at = (hold_win[2] == 8'h00) ? 4 : 3;
        // type byte not yet in the window at packet end: unit is kept
        if (type_at < hold_cnt) unit_kept = !unit_dropped(hold_win[type_at]);
      end
    end
    if (unit_kept && step_out.size() < MAX_PER_REQ) begin
      step_out.push_back('{out_byte: hold_win[0], byte_valid: 1'b1, packet_end: 1'b0});
    end
    if (hold_win[0] == 8'h00) begin
      if (zeros_seen < 2'd2) zeros_seen = zeros_seen + 2'd1;
    end else begin
      zeros_seen = 2'd0;
    end
    if (unit_pos < 3'd7) unit_pos = unit_pos + 3'd1;
    for (int k = 0; k < HOLD_DEPTH - 1; k++) hold_win[k] = hold_win[k+1];
    hold_win[HOLD_DEPTH-1] = 8'h00;
    hold_cnt = hold_cnt - 1;
  endfunction

  // works out what one accepted byte request makes the block send
  function automatic void filter_accept(input nalf_pkg::byte_t b, input logic last);
    filt_res_t tail;
    step_out.delete();
    if (hold_cnt >= HOLD_DEPTH) emit_head();
    hold_win[hold_cnt] = b;
    hold_cnt = hold_cnt + 1;
    if (pkt_len < 3'd7) pkt_len = pkt_len + 3'd1;
    if (!last) begin
      if (hold_cnt >= HOLD_DEPTH) emit_head();
    end else begin
      // short packets release nothing, only the end marker
      if (pkt_len >= 3'd4) begin
        while (hold_cnt > 0) emit_head();
      end
      if (step_out.size() == 0) begin
        step_out.push_back('{out_byte: 8'h00, byte_valid: 1'b0, packet_end: 1'b1});
      end else begin
        tail = step_out.pop_back();
        tail.packet_end = 1'b1;
        step_out.push_back(tail);
      end
      clear_packet();
    end
    foreach (step_out[k]) filtered_q.push_back(step_out[k]);
  endfunction

  // ------------------------------------------------------------------------
  // monitor: prediction on accepted requests, comparison on accepted results
  // both sampled at the same edge so ordering inside the step does not matter
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) codec_h265 = cfg_data;
      if (s_tvalid && s_tready) filter_accept(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        seen_res = '{out_byte: m_tdata, byte_valid: m_tuser, packet_end: m_tlast};
        if (filtered_q.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected: actual byte %h valid %b end %b",
                   $time, seen_res.out_byte, seen_res.byte_valid, seen_res.packet_end);
        end else begin
          want_res = filtered_q.pop_front();
          if (seen_res !== want_res) begin
            errors++;
            $display("%0t: expected byte %h valid %b end %b, actual byte %h valid %b end %b",
                     $time, want_res.out_byte, want_res.byte_valid, want_res.packet_end,
                     seen_res.out_byte, seen_res.byte_valid, seen_res.packet_end);
          end
        end
      end
    end
  end

  // receiver: stalls at random about 11 percent of the time unless a steady stretch runs
  always @(posedge clk) begin
    m_tready <= steady || ($urandom_range(99) >= 11);
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[nal_unit_type_filter_top] ERROR");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // stimulus helpers
  // ------------------------------------------------------------------------

  // one byte request, with random idle cycles in front unless steady is set
  task automatic send_byte(input nalf_pkg::byte_t b, input logic last);
    if (!steady) begin
      while ($urandom_range(99) < 11) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
  endtask

  // waits until every predicted result has left; the queue is checked after each clock edge
  task automatic wait_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (filtered_q.size() != 0);
  endtask

  // whole packet; optionally holds off mid packet until the output is empty
  task automatic send_packet(input nalf_pkg::byte_t pkt[$], input bit hold_mid);
    foreach (pkt[k]) begin
      if (hold_mid && k == pkt.size() / 2 && k != 0) wait_results();
      send_byte(pkt[k], k == pkt.size() - 1);
    end
  endtask

  // codec_select write while the block is quiet
  task automatic set_codec(input logic sel);
    wait_results();
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= sel;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // type byte: often one of the dropped types of either codec
  function automatic nalf_pkg::byte_t pick_type();
    nalf_pkg::byte_t t;
    t = nalf_pkg::byte_t'($urandom_range(255));
    case ($urandom_range(3))
      0: t[4:0] = $urandom_range(1) ? nalf_pkg::H264_SEI : nalf_pkg::H264_AUD;
      1: t[6:1] = $urandom_range(1) ? nalf_pkg::H265_AUD : nalf_pkg::H265_SEI;
      default: ;
    endcase
    return t;
  endfunction

  // payload byte, biased toward start code material
  function automatic nalf_pkg::byte_t pick_body();
    case ($urandom_range(5))
      0, 1: return 8'h00;
      2: return 8'h01;
      default: return nalf_pkg::byte_t'($urandom_range(255));
    endcase
  endfunction

  // ------------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------------

  // packets below four bytes give only the end marker
  task automatic test_short_packets();
    set_codec(nalf_pkg::CODEC_H264);
    send_packet('{8'hFF}, 1'b0);
    send_packet('{8'h00, 8'h00, 8'h01}, 1'b0);
  endtask

  // h.264: access unit delimiter dropped, following slice kept
  task automatic test_h264_units();
    send_packet('{8'h00, 8'h00, 8'h01, 8'h09, 8'hF0,
                  8'h00, 8'h00, 8'h01, 8'h65, 8'h80}, 1'b0);
  endtask

  // start code at the very end, type byte never arrives
  task automatic test_missing_type();
    send_packet('{8'h41, 8'h42, 8'h43, 8'h00, 8'h00, 8'h01}, 1'b0);
  endtask

  // h.265: four-byte start code sei dropped, following unit kept
  task automatic test_h265_units();
    set_codec(nalf_pkg::CODEC_H265);
    send_packet('{8'h00, 8'h00, 8'h00, 8'h01, 8'h4E,
                  8'h01, 8'h00, 8'h00, 8'h01, 8'h40}, 1'b0);
  endtask

  // random packets over several codec phases, one phase with no receiver stalls or send_byte idles
  task automatic test_random_streams();
    nalf_pkg::byte_t pkt[$];
    int    goal;
    int    units;
    int    body;
    logic  phase_codec [4];
    phase_codec = '{nalf_pkg::CODEC_H264, nalf_pkg::CODEC_H265,
                    nalf_pkg::CODEC_H265, nalf_pkg::CODEC_H264};
    for (int ph = 0; ph < 4; ph++) begin
      set_codec(phase_codec[ph]);
      steady = (ph == 2);
      goal = sent + RAND_ITEMS / 4;
      while (sent < goal) begin
        pkt.delete();
        if ($urandom_range(3) == 0) begin
          // noise
          repeat ($urandom_range(1, 12)) pkt.push_back(pick_body());
        end else begin
          units = $urandom_range(1, 4);
          repeat (units) begin
            if ($urandom_range(1)) pkt.push_back(8'h00);
            pkt.push_back(8'h00);
            pkt.push_back(8'h00);
            pkt.push_back(8'h01);
            pkt.push_back(pick_type());
            body = $urandom_range(0, 5);
            repeat (body) pkt.push_back(pick_body());
          end
          // broken sequence: cut anywhere
          if ($urandom_range(7) == 0) begin
            while (pkt.size() > 1 && $urandom_range(3) != 0) void'(pkt.pop_back());
          end
        end
        send_packet(pkt, $urandom_range(9) == 0);
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    errors     = 0;
    cycles     = 0;
    sent       = 0;
    steady     = 1'b0;
    codec_h265 = nalf_pkg::CODEC_H264;
    clear_packet();
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= 8'h00;
    s_tlast   <= 1'b0;
    m_tready  <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data  <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_short_packets();
    test_h264_units();
    test_missing_type();
    test_h265_units();
    test_random_streams();

    // let everything drain before judging
    wait_results();
    repeat (SETTLE) @(posedge clk);
    if (errors == 0 && filtered_q.size() == 0) begin
      $display("[nal_unit_type_filter_top] OK");
    end else begin
      $display("[nal_unit_type_filter_top] ERROR");
    end
    $finish;
  end

endmodule
